FILE: rtl/aes128_ctr_stream_defines.svh
// Assertion macros shared by the AES-128 CTR stream checker.
`ifndef AES128_CTR_STREAM_DEFINES_SVH
`define AES128_CTR_STREAM_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ACS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ACS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/acs_pkg.sv
// Package with types, constants and AES helper functions for the CTR stream.
package acs_pkg;

    localparam int BlockBytes = 16;
    localparam int Rounds     = 10;
    localparam int FifoDepth  = 4;
    localparam int CfgIdxW    = 2;

    localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [1:0] REG_CTR_HIGH  = 2'd2;
    localparam logic [1:0] REG_CTR_LOW   = 2'd3;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  valid_bytes;
        logic        restart;
    } in_word_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } out_word_t;

    // Classified word handed from the front part to the cipher pipeline.
    typedef struct packed {
        logic [127:0] data;
        logic [127:0] ctr;
        logic [15:0]  mask;
    } job_t;

    typedef logic [7:0] sbox_t [256];

    localparam sbox_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        get_byte = v[127 - 8 * i -: 8];
    endfunction

    // One key expansion step: next round key from the current one.
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    // One cipher round without the round key addition.
    function automatic logic [127:0] round_core(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[j + 4 * c] = SBOX[get_byte(s, j + 4 * ((c + j) & 3))];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ al ^ xt(a0 ^ a1);
                t[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
                t[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
                t[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = t[i];
        end
        round_core = r;
    endfunction

endpackage

FILE: rtl/acs_front.sv
// Front part: owns the counter, classifies each word and builds a cipher job.
module acs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  acs_pkg::in_word_t in_word,
    input  logic              take,
    input  logic [127:0]      ctr_init,
    output acs_pkg::job_t     job
);
    import acs_pkg::*;

    logic [127:0] ctr_reg;
    logic [127:0] ctr_next;
    logic [127:0] ctr_use;
    logic [4:0]   nvalid;

    always_comb begin
        ctr_use = in_word.restart ? ctr_init : ctr_reg;
        nvalid  = (in_word.valid_bytes > 5'd16) ? 5'd16 : in_word.valid_bytes;
        for (int i = 0; i < BlockBytes; i++) begin
            job.mask[15 - i] = (5'(i) < nvalid);
        end
        job.data = {in_word.data_high, in_word.data_low};
        job.ctr  = ctr_use;
        ctr_next = (nvalid == 5'd16) ? ctr_use + 128'd1 : ctr_use;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
        end else if (take) begin
            ctr_reg <= ctr_next;
        end
    end

endmodule

FILE: rtl/acs_fifo.sv
// Short queue of cipher jobs between the front part and the cipher pipeline.
module acs_fifo #(
    parameter int Depth = acs_pkg::FifoDepth
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  acs_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output acs_pkg::job_t rd_job
);
    import acs_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    job_t          mem_reg [Depth];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          wr_en, rd_en;

    assign wr_ready = (cnt_reg != (AW+1)'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_comb begin
        wp_next  = (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
        rp_next  = (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
        cnt_next = cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) begin
                wp_reg <= wp_next;
            end
            if (rd_en) begin
                rp_reg <= rp_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

endmodule

FILE: rtl/acs_cipher.sv
// Back part: ten-round unrolled AES-128 pipeline with stall, keystream XOR and mask.
module acs_cipher (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [127:0]      key,
    input  logic              in_valid,
    output logic              in_ready,
    input  acs_pkg::job_t     in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output acs_pkg::out_word_t out_word
);
    import acs_pkg::*;

    // Stage 0 holds the whitened state; stages 1..10 hold states after each round.
    logic [127:0] st_reg   [Rounds + 1];
    logic [127:0] rk_reg   [Rounds + 1];
    logic [127:0] dat_reg  [Rounds + 1];
    logic [15:0]  msk_reg  [Rounds + 1];
    logic [7:0]   rc_reg   [Rounds + 1];
    logic [Rounds:0] vld_reg;
    logic         adv;
    logic [127:0] res;

    assign out_valid = vld_reg[Rounds];
    assign adv       = !vld_reg[Rounds] || out_ready;
    assign in_ready  = adv;

    always_comb begin
        res = st_reg[Rounds] ^ dat_reg[Rounds];
        for (int i = 0; i < BlockBytes; i++) begin
            if (!msk_reg[Rounds][15 - i]) begin
                res[127 - 8 * i -: 8] = 8'h00;
            end
        end
        out_word.out_high = res[127:64];
        out_word.out_low  = res[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[Rounds-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0]  <= in_job.ctr ^ key;
            rk_reg[0]  <= key;
            dat_reg[0] <= in_job.data;
            msk_reg[0] <= in_job.mask;
            rc_reg[0]  <= 8'h01;
            for (int r = 1; r <= Rounds; r++) begin
                rk_reg[r]  <= next_key(rk_reg[r-1], rc_reg[r-1]);
                st_reg[r]  <= round_core(st_reg[r-1], r == Rounds)
                              ^ next_key(rk_reg[r-1], rc_reg[r-1]);
                dat_reg[r] <= dat_reg[r-1];
                msk_reg[r] <= msk_reg[r-1];
                rc_reg[r]  <= xt(rc_reg[r-1]);
            end
        end
    end

endmodule

FILE: rtl/aes128_ctr_stream.sv
// Top level of the AES-128 counter mode stream block.
//
//   Channel   Ports                   Carries
//   input     s_valid s_ready s_word  data block, valid byte count, restart
//   result    m_valid m_ready m_word  masked keystream XOR result
//   config    cfg_we cfg_idx cfg_data key and initial counter registers
//
// One word is accepted per cycle while the queue has room.
// The ten rounds are unrolled, one pipeline stage each, after the key whitening stage.
// Reset is synchronous and clears the counter, registers, queue and valid bits.
// A stalled result holds the whole pipeline; the queue absorbs front words.
module aes128_ctr_stream #(
    parameter int FifoDepth = acs_pkg::FifoDepth
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  acs_pkg::in_word_t           s_word,
    output logic                        m_valid,
    input  logic                        m_ready,
    output acs_pkg::out_word_t          m_word,
    input  logic                        cfg_we,
    input  logic [acs_pkg::CfgIdxW-1:0] cfg_idx,
    input  logic [63:0]                 cfg_data
);
    import acs_pkg::*;

    logic [63:0] key_high_reg, key_low_reg, ctr_high_reg, ctr_low_reg;
    job_t        front_job, q_job;
    logic        take, q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            ctr_high_reg <= '0;
            ctr_low_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_CTR_HIGH: ctr_high_reg <= cfg_data;
                REG_CTR_LOW:  ctr_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign take = s_valid && s_ready;

    acs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_word  (s_word),
        .take     (take),
        .ctr_init ({ctr_high_reg, ctr_low_reg}),
        .job      (front_job)
    );

    acs_fifo #(.Depth(FifoDepth)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_job   (front_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job)
    );

    acs_cipher u_cipher (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key       ({key_high_reg, key_low_reg}),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_job    (q_job),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word)
    );

endmodule

FILE: rtl/acs_checker.sv
// Port-level checker for the AES-128 CTR stream, bound to the top level.
`include "aes128_ctr_stream_defines.svh"
module acs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input acs_pkg::out_word_t m_word
);
    `ACS_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ACS_ASSERT_NXT(a_m_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_word))
    `ACS_ASSERT_NXT(a_no_early, aclk, aresetn, $fell(aresetn) || !aresetn, !m_valid)
    `ACS_ASSERT_IMP(a_ready_known, aclk, aresetn, s_valid, s_ready == 1'b1 || s_ready == 1'b0)
endmodule

bind aes128_ctr_stream acs_checker u_acs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
